// File: hw/rtl/dmdf_pkg.sv
// dmdf_pkg: shared types and constants for the direct-mapped duplicate filter
// used by the front, queue, back and top-level modules; no dependencies
`default_nettype none

package dmdf_pkg;

    localparam int DIGEST_W      = 128;
    localparam int HALF_W        = 64;
    localparam int KIND_W        = 2;
    // digest bits folded into the remainder per cycle by the front
    localparam int BITS_PER_STEP = 4;
    localparam int REDUCE_STEPS  = DIGEST_W / BITS_PER_STEP;
    localparam int STEP_W        = $clog2(REDUCE_STEPS);
    localparam int QDEPTH        = 2;
    localparam int QPTR_W        = $clog2(QDEPTH);

    typedef enum logic [KIND_W-1:0] {
        KIND_APPLY     = 2'd0,
        KIND_CLEAR_ONE = 2'd1,
        KIND_CLEAR_ALL = 2'd2
    } kind_e;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [HALF_W-1:0] digest_hi;
        logic [HALF_W-1:0] digest_lo;
    } item_t;

    localparam int ITEM_W = $bits(item_t);

    typedef struct packed {
        logic init_done;
        logic busy;
    } back_status_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_REDUCE,
        F_PUSH
    } front_state_e;

    typedef enum logic [1:0] {
        B_SWEEP,
        B_IDLE,
        B_CHECK
    } back_state_e;

endpackage

`default_nettype wire

// File: hw/rtl/direct_mapped_duplicate_filter.sv
// direct_mapped_duplicate_filter: top level of the duplicate digest filter
// depends on dmdf_pkg, dmdf_front, dmdf_queue and dmdf_back
//
// Input channel (in_valid/in_ready) carries kind, digest_hi and digest_lo.
// Kind apply tests the digest against its slot (digest mod SLOTS) and
// inserts it on a miss; one result transfer on the out channel
// (out_valid/out_ready, already_seen) follows each apply. Clear-one zeroes
// the slot when it holds the digest, clear-all zeroes the table; neither
// gives a result, and the unused kind is dropped.
// An apply passes from the input transfer through the queue and the back end
// to the result register; when SLOTS is not a power of two, the front first
// folds the 128-bit digest into the remainder four bits a cycle.
// The back end handles each apply or clear-one as a memory read, then a
// compare and write on the one memory port, and takes no new item from the
// queue until it is done with the last; for SLOTS not a power of two the
// front likewise takes no new item until the last is pushed. Clear-all
// writes zero to one slot a cycle. After reset the table is swept to zero;
// in_ready stays low until that sweep is done.
// A stalled receiver holds the result register; the two-entry queue keeps
// taking items until it fills, then in_ready drops.
`default_nettype none

module direct_mapped_duplicate_filter #(
    parameter int SLOTS = 1024
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [dmdf_pkg::KIND_W-1:0] kind,
    input  wire logic [dmdf_pkg::HALF_W-1:0] digest_hi,
    input  wire logic [dmdf_pkg::HALF_W-1:0] digest_lo,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic                             already_seen
);
    import dmdf_pkg::*;

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int QW    = ITEM_W + IDX_W;

    back_status_t      status;
    logic              q_full;
    logic              q_not_empty;
    logic              push;
    item_t             push_item;
    logic [IDX_W-1:0]  push_idx;
    logic              q_pop;
    logic [QW-1:0]     q_head;
    item_t             q_item;
    logic [IDX_W-1:0]  q_idx;

    dmdf_front #(
        .SLOTS (SLOTS),
        .IDX_W (IDX_W)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .kind      (kind),
        .digest_hi (digest_hi),
        .digest_lo (digest_lo),
        .status    (status),
        .q_full    (q_full),
        .push      (push),
        .push_item (push_item),
        .push_idx  (push_idx)
    );

    dmdf_queue #(
        .DW (QW)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data ({push_item, push_idx}),
        .pop       (q_pop),
        .head      (q_head),
        .full      (q_full),
        .not_empty (q_not_empty)
    );

    assign q_item = q_head[QW-1:IDX_W];
    assign q_idx  = q_head[IDX_W-1:0];

    dmdf_back #(
        .SLOTS (SLOTS),
        .IDX_W (IDX_W)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_not_empty),
        .q_item       (q_item),
        .q_idx        (q_idx),
        .q_pop        (q_pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .already_seen (already_seen),
        .status       (status)
    );

    a_hold_until_init: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> status.init_done)
        else $error("input taken before the table sweep finished");

endmodule

`default_nettype wire

// File: hw/rtl/dmdf_front.sv
// dmdf_front: accepts items and works out the slot index (digest mod SLOTS)
// depends on dmdf_pkg; feeds dmdf_queue
`default_nettype none

module dmdf_front #(
    parameter int SLOTS = 1024,
    parameter int IDX_W = 10
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [dmdf_pkg::KIND_W-1:0]   kind,
    input  wire logic [dmdf_pkg::HALF_W-1:0]   digest_hi,
    input  wire logic [dmdf_pkg::HALF_W-1:0]   digest_lo,
    input  wire dmdf_pkg::back_status_t        status,
    input  wire logic                          q_full,
    output logic                               push,
    output dmdf_pkg::item_t                    push_item,
    output logic [IDX_W-1:0]                   push_idx
);
    import dmdf_pkg::*;

    localparam bit IS_POW2 = ((SLOTS & (SLOTS - 1)) == 0);

    generate
        if (IS_POW2) begin : g_pow2
            // slot is just the low digest bits, so items go straight into the queue
            assign in_ready            = status.init_done && !q_full;
            assign push                = in_valid && in_ready;
            assign push_item.kind      = kind;
            assign push_item.digest_hi = digest_hi;
            assign push_item.digest_lo = digest_lo;
            assign push_idx            = (SLOTS == 1) ? '0 : digest_lo[IDX_W-1:0];
        end else begin : g_reduce
            localparam logic [IDX_W:0] SLOTS_W = (IDX_W+1)'(SLOTS);
            localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(REDUCE_STEPS - 1);

            front_state_e          state_reg, state_next;
            item_t                 item_reg;
            logic [DIGEST_W-1:0]   shift_reg, shift_next;
            logic [IDX_W-1:0]      rem_reg, rem_next;
            logic [STEP_W-1:0]     step_reg, step_next;
            logic                  accept;
            logic                  needs_idx;
            logic [IDX_W-1:0]      rem_fold;

            assign accept    = in_valid && in_ready;
            assign needs_idx = (kind == KIND_APPLY) || (kind == KIND_CLEAR_ONE);

            // fold BITS_PER_STEP digest bits, msb first, into the running remainder
            always_comb
            begin
                logic [IDX_W:0]   v;
                logic [IDX_W-1:0] t;
                t = rem_reg;
                for (int k = 0; k < BITS_PER_STEP; k++)
                begin
                    v = {t, shift_reg[DIGEST_W-1-k]};
                    if (v >= SLOTS_W)
                    begin
                        v = v - SLOTS_W;
                    end
                    t = v[IDX_W-1:0];
                end
                rem_fold = t;
            end

            always_comb
            begin
                state_next = state_reg;
                case (state_reg)
                    F_IDLE:
                    begin
                        if (accept)
                        begin
                            state_next = needs_idx ? F_REDUCE : F_PUSH;
                        end
                    end
                    F_REDUCE:
                    begin
                        if (step_reg == LAST_STEP)
                        begin
                            state_next = F_PUSH;
                        end
                    end
                    F_PUSH:
                    begin
                        if (!q_full)
                        begin
                            state_next = F_IDLE;
                        end
                    end
                    default: state_next = F_IDLE;
                endcase
            end

            always_comb
            begin
                in_ready   = 1'b0;
                push       = 1'b0;
                shift_next = shift_reg;
                rem_next   = rem_reg;
                step_next  = step_reg;
                case (state_reg)
                    F_IDLE:
                    begin
                        in_ready   = status.init_done;
                        shift_next = {digest_hi, digest_lo};
                        rem_next   = '0;
                        step_next  = '0;
                    end
                    F_REDUCE:
                    begin
                        shift_next = shift_reg << BITS_PER_STEP;
                        rem_next   = rem_fold;
                        step_next  = step_reg + 1'b1;
                    end
                    F_PUSH:
                    begin
                        push = !q_full;
                    end
                    default:
                    begin
                        push = 1'b0;
                    end
                endcase
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    state_reg <= F_IDLE;
                    step_reg  <= '0;
                end
                else
                begin
                    state_reg <= state_next;
                    step_reg  <= step_next;
                end
            end

            always_ff @(posedge clk)
            begin
                shift_reg <= shift_next;
                rem_reg   <= rem_next;
                if (accept)
                begin
                    item_reg.kind      <= kind;
                    item_reg.digest_hi <= digest_hi;
                    item_reg.digest_lo <= digest_lo;
                end
            end

            assign push_item = item_reg;
            assign push_idx  = rem_reg;
        end
    endgenerate

endmodule

`default_nettype wire

// File: hw/rtl/dmdf_queue.sv
// dmdf_queue: short fifo between the front and the back
// depends on dmdf_pkg for its depth
`default_nettype none

module dmdf_queue #(
    parameter int DW = 140
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire logic [DW-1:0] push_data,
    input  wire logic          pop,
    output logic [DW-1:0]      head,
    output logic               full,
    output logic               not_empty
);
    import dmdf_pkg::*;

    logic [DW-1:0]     mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_W:0]   count_reg, count_next;

    assign full      = (count_reg == (QPTR_W+1)'(QDEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!full || pop))
        else $error("queue pushed while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> not_empty)
        else $error("queue popped while empty");

endmodule

`default_nettype wire

// File: hw/rtl/dmdf_back.sv
// dmdf_back: slot memory, read-compare-write sequencer, table sweep and output register
// depends on dmdf_pkg; takes items from dmdf_queue
`default_nettype none

module dmdf_back #(
    parameter int SLOTS = 1024,
    parameter int IDX_W = 10
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 q_valid,
    input  wire dmdf_pkg::item_t      q_item,
    input  wire logic [IDX_W-1:0]     q_idx,
    output logic                      q_pop,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic                      already_seen,
    output dmdf_pkg::back_status_t    status
);
    import dmdf_pkg::*;

    localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(SLOTS - 1);

    logic [DIGEST_W-1:0] slot_mem [SLOTS];
    logic [DIGEST_W-1:0] rd_data_reg;

    back_state_e          state_reg, state_next;
    logic                 init_done_reg;
    logic [IDX_W-1:0]     sweep_reg, sweep_next;
    item_t                work_reg;
    logic [IDX_W-1:0]     work_idx_reg;
    logic                 out_valid_reg;
    logic                 seen_reg;

    logic                 rd_en;
    logic                 wr_en;
    logic [IDX_W-1:0]     wr_addr;
    logic [DIGEST_W-1:0]  wr_data;
    logic                 out_load;
    logic                 out_free;
    logic                 match;
    logic                 sweep_done;

    assign out_free   = !out_valid_reg || out_ready;
    assign match      = (rd_data_reg == {work_reg.digest_hi, work_reg.digest_lo});
    assign sweep_done = (sweep_reg == LAST_SLOT);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_SWEEP:
            begin
                if (sweep_done)
                begin
                    state_next = B_IDLE;
                end
            end
            B_IDLE:
            begin
                if (q_valid)
                begin
                    case (q_item.kind)
                        KIND_APPLY, KIND_CLEAR_ONE: state_next = B_CHECK;
                        KIND_CLEAR_ALL:             state_next = B_SWEEP;
                        default:                    state_next = B_IDLE;
                    endcase
                end
            end
            B_CHECK:
            begin
                if (work_reg.kind != KIND_APPLY || out_free)
                begin
                    state_next = B_IDLE;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_comb
    begin
        q_pop      = 1'b0;
        rd_en      = 1'b0;
        wr_en      = 1'b0;
        wr_addr    = work_idx_reg;
        wr_data    = '0;
        out_load   = 1'b0;
        sweep_next = sweep_reg;
        case (state_reg)
            B_SWEEP:
            begin
                wr_en      = 1'b1;
                wr_addr    = sweep_reg;
                sweep_next = sweep_reg + 1'b1;
            end
            B_IDLE:
            begin
                q_pop      = q_valid;
                rd_en      = q_valid;
                sweep_next = '0;
            end
            B_CHECK:
            begin
                if (work_reg.kind == KIND_APPLY)
                begin
                    // a fresh digest takes over the slot
                    out_load = out_free;
                    wr_en    = out_free && !match;
                    wr_data  = {work_reg.digest_hi, work_reg.digest_lo};
                end
                else
                begin
                    wr_en = match;
                end
            end
            default:
            begin
                q_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_SWEEP;
            sweep_reg     <= '0;
            init_done_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            sweep_reg <= sweep_next;
            if (state_reg == B_SWEEP && sweep_done)
            begin
                init_done_reg <= 1'b1;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            work_reg     <= q_item;
            work_idx_reg <= q_idx;
        end
        if (out_load)
        begin
            seen_reg <= match;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= slot_mem[q_idx];
        end
    end

    assign out_valid        = out_valid_reg;
    assign already_seen     = seen_reg;
    assign status.init_done = init_done_reg;
    assign status.busy      = (state_reg != B_IDLE);

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> out_free)
        else $error("result register overwritten before transfer");

    a_init_after_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(init_done_reg) |-> $past(state_reg == B_SWEEP))
        else $error("table marked ready without a sweep");

    a_no_pop_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (state_reg == B_IDLE))
        else $error("queue popped while back end busy");

endmodule

`default_nettype wire
